// ===== rtl/core/uricn_pkg.sv =====
// ============================================================================
// uricn_pkg
// Shared types, codes and character class functions for the URI component
// character normalizer.
// ============================================================================
package uricn_pkg;

    // Component modes held in the mode register.
    localparam logic [2:0] MODE_SCHEME = 3'd0;
    localparam logic [2:0] MODE_HOST   = 3'd1;
    localparam logic [2:0] MODE_PORT   = 3'd2;
    localparam logic [2:0] MODE_PATH   = 3'd3;
    localparam logic [2:0] MODE_IPV4   = 3'd4;

    // Status codes reported with every result.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ILLEGAL     = 3'd1;
    localparam logic [2:0] ST_RANGE       = 3'd2;
    localparam logic [2:0] ST_NO_SCHEME   = 3'd3;
    localparam logic [2:0] ST_BAD_EMPTY   = 3'd4;

    // Escape progress.
    localparam logic [1:0] ESC_NONE   = 2'd0;
    localparam logic [1:0] ESC_FIRST  = 2'd1;
    localparam logic [1:0] ESC_SECOND = 2'd2;

    // Characters with a role of their own.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // IPv4 octet limits.
    localparam logic [9:0] OCTET_MAX      = 10'd255;
    localparam logic [9:0] OCTET_MIN_3DIG = 10'd100;
    localparam logic [9:0] OCTET_MIN_2DIG = 10'd10;
    localparam logic [2:0] OCTET_LIMIT    = 3'd4;
    localparam logic [2:0] OCTET_COUNT_SAT = 3'd7;
    localparam logic [2:0] OCTET_DIG_MAX  = 3'd3;
    localparam logic [2:0] OCTET_DIG_OVER = 3'd4;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
        logic       empty_component;
    } item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       end_of_component;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic [1:0] escape_phase;
        logic [2:0] sticky_status;
        logic       at_first_byte;
        logic [2:0] octet_digits;
        logic [9:0] octet_value;
        logic [2:0] octet_count;
    } comp_state_t;

    localparam comp_state_t COMP_RESET = '{
        escape_phase:  ESC_NONE,
        sticky_status: ST_OK,
        at_first_byte: 1'b1,
        octet_digits:  3'd0,
        octet_value:   10'd0,
        octet_count:   3'd0
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic is_unres(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h2D || c == 8'h2E ||
               c == 8'h5F || c == 8'h7E;
    endfunction

    function automatic logic is_sub(input logic [7:0] c);
        return c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 ||
               c == 8'h28 || c == 8'h29 || c == 8'h2A || c == 8'h2B ||
               c == 8'h2C || c == 8'h3B || c == 8'h3D;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
    endfunction

    // Records a status code only if none has been recorded yet.
    function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

    // Checks the octet that is just finished and starts a new one.
    function automatic comp_state_t close_octet(input comp_state_t s);
        comp_state_t r;
        r = s;
        if (s.octet_digits == 3'd0) begin
            r.sticky_status = flag(r.sticky_status, ST_ILLEGAL);
        end else if (s.octet_digits == 3'd2 && s.octet_value < OCTET_MIN_2DIG) begin
            r.sticky_status = flag(r.sticky_status, ST_ILLEGAL);
        end else if (s.octet_digits == 3'd3 &&
                     (s.octet_value < OCTET_MIN_3DIG || s.octet_value > OCTET_MAX)) begin
            r.sticky_status = flag(r.sticky_status, ST_ILLEGAL);
        end
        if (s.octet_count < OCTET_COUNT_SAT) begin
            r.octet_count = s.octet_count + 3'd1;
        end
        r.octet_digits = 3'd0;
        r.octet_value  = 10'd0;
        return r;
    endfunction

    // Checks that run when a component ends after at least one byte.
    function automatic comp_state_t end_checks(input comp_state_t s, input logic [2:0] mode);
        comp_state_t r;
        r = s;
        if (r.escape_phase != ESC_NONE) begin
            r.sticky_status = flag(r.sticky_status, ST_ILLEGAL);
        end
        if (mode == MODE_IPV4) begin
            r = close_octet(r);
            if (r.octet_count < OCTET_LIMIT) begin
                r.sticky_status = flag(r.sticky_status, ST_ILLEGAL);
            end
        end else if (mode > MODE_IPV4) begin
            r.sticky_status = flag(r.sticky_status, ST_ILLEGAL);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/uricn_step.sv =====
// ============================================================================
// uricn_step
// One byte's worth of checking and normalization: takes the held beat and the
// component state and gives the result and the next component state.
// ============================================================================
module uricn_step
    import uricn_pkg::*;
(
    input  logic [2:0]  mode,
    input  item_t       item,
    input  comp_state_t cur,
    output result_t     result,
    output comp_state_t nxt
);

    comp_state_t s;
    logic [7:0]  c;
    logic [7:0]  ch;
    logic        last;
    logic [13:0] scaled;

    assign c = item.char_in;

    always_comb
    begin
        s      = cur;
        ch     = 8'd0;
        last   = 1'b1;
        scaled = {4'd0, cur.octet_value} * 14'd10 + {6'd0, c - CH_ZERO};

        if (item.empty_component) begin
            if (cur.at_first_byte) begin
                if (mode == MODE_SCHEME) begin
                    s.sticky_status = flag(s.sticky_status, ST_NO_SCHEME);
                end else if (mode == MODE_PATH || mode == MODE_IPV4) begin
                    s.sticky_status = flag(s.sticky_status, ST_BAD_EMPTY);
                end else if (mode > MODE_IPV4) begin
                    s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                end
            end else begin
                s = end_checks(s, mode);
            end
        end else begin
            unique case (mode) inside
                MODE_SCHEME:
                begin
                    if (cur.at_first_byte && !is_alpha(c)) begin
                        s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                    end
                    if (!(is_alpha(c) || is_digit(c) || c == CH_PLUS ||
                          c == CH_MINUS || c == CH_DOT)) begin
                        s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                    end
                    ch = to_lower(c);
                end
                MODE_HOST, MODE_PATH:
                begin
                    if (cur.escape_phase != ESC_NONE) begin
                        if (!is_hex(c)) begin
                            s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                        end
                        s.escape_phase = (cur.escape_phase == ESC_FIRST) ? ESC_SECOND
                                                                         : ESC_NONE;
                        ch = to_upper(c);
                    end else if (c == CH_PERCENT) begin
                        s.escape_phase = ESC_FIRST;
                        ch = c;
                    end else if (mode == MODE_HOST) begin
                        if (!(is_sub(c) || is_unres(c))) begin
                            s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                        end
                        ch = to_lower(c);
                    end else begin
                        if (!(is_unres(c) || is_sub(c) || c == CH_COLON ||
                              c == CH_AT || c == CH_SLASH)) begin
                            s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                        end
                        ch = c;
                    end
                end
                MODE_PORT:
                begin
                    if (!is_digit(c)) begin
                        s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                    end
                    ch = c;
                end
                MODE_IPV4:
                begin
                    if (c == CH_DOT) begin
                        s = close_octet(s);
                        if (s.octet_count >= OCTET_LIMIT) begin
                            s.sticky_status = flag(s.sticky_status, ST_RANGE);
                        end
                    end else if (is_digit(c)) begin
                        if (cur.octet_digits >= OCTET_DIG_MAX) begin
                            s.sticky_status = flag(s.sticky_status, ST_RANGE);
                            s.octet_digits  = OCTET_DIG_OVER;
                        end else begin
                            s.octet_value  = scaled[9:0];
                            s.octet_digits = cur.octet_digits + 3'd1;
                        end
                    end else begin
                        s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                    end
                    ch = c;
                end
                default:
                begin
                    s.sticky_status = flag(s.sticky_status, ST_ILLEGAL);
                    ch = c;
                end
            endcase
            s.at_first_byte = 1'b0;
            last = item.last_char;
            if (item.last_char) begin
                s = end_checks(s, mode);
            end
        end

        result.char_out         = ch;
        result.end_of_component = last;
        result.status           = s.sticky_status;
        nxt = last ? COMP_RESET : s;
    end

endmodule

// ===== rtl/core/uri_component_char_normalizer.sv =====
// ============================================================================
// uri_component_char_normalizer
// Top level: input beat register, per-byte step logic, component state and
// the result register, with valid/stall handshakes on both sides.
// ============================================================================
// A held beat moves to the result register when that is empty or taken.
// Throughput: one beat per cycle while the result side does not stall; the
// step logic holds no loop, so beats follow back to back.
// Reset (rst_n low, asynchronous): mode register goes to scheme, component
// state returns to its start values, and both stages are emptied.
module uri_component_char_normalizer
    import uricn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // Configuration: component mode register.
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,

    // Input beats.
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,

    // Result beats.
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result
);

    logic [2:0]  mode_reg;
    logic        hold_valid_reg;
    item_t       hold_reg;
    comp_state_t state_reg;
    comp_state_t state_next;
    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    logic        item_accept;
    logic        advance;
    logic        fire;

    // The held beat moves on whenever the result register is empty or is
    // being taken in the same cycle. The input side only stalls when the held
    // beat cannot move, so a waiting result never blocks a new beat by itself.
    assign advance     = !result_valid_reg || !result_stall;
    assign fire        = hold_valid_reg && advance;
    assign item_stall  = hold_valid_reg && !advance;
    assign item_accept = item_valid && !item_stall;

    // Mode register. The user writes only while the block is idle; not checked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_SCHEME;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Input beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else if (item_accept) begin
            hold_valid_reg <= 1'b1;
        end else if (fire) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept) begin
            hold_reg <= item;
        end
    end

    // Per-byte checks and normalization.
    uricn_step u_step (
        .mode   (mode_reg),
        .item   (hold_reg),
        .cur    (state_reg),
        .result (result_next),
        .nxt    (state_next)
    );

    // Component state advances once per beat that reaches the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= COMP_RESET;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (fire) begin
            result_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== tb/tb_uri_component_char_normalizer.sv =====
// ============================================================================
// tb_uri_component_char_normalizer
// Self-checking regression for the URI component character normalizer. A
// short directed pass walks each component mode, the empty-component cases,
// escapes, IPv4 octets and a spare mode code. A long random pass then
// streams mostly well-formed components with noise mixed in. Every accepted
// input beat is run through a local model of the component rules, and every
// result beat is compared field by field against the oldest prediction.
// Both handshakes see random gaps and stalls.
// ============================================================================
module tb_uri_component_char_normalizer;
    timeunit 1ns;
    timeprecision 1ps;

    import uricn_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int REPORT_LIMIT = 40;
    // A short pause after the last result leaves the pipeline empty before a
    // mode write.
    localparam int IDLE_PAUSE   = 4;

    // Mode codes that the block treats as unused.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts known.
    // ------------------------------------------------------------------------
    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       cfg_we       = 1'b0;
    logic [2:0] cfg_wdata    = 3'd0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    item_t      item         = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;

    always #(CLK_PERIOD / 2) clk = ~clk;

    uri_component_char_normalizer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // ------------------------------------------------------------------------
    // Bookkeeping shared by the stimulus and the result monitor.
    // ------------------------------------------------------------------------
    result_t     pending_results[$];   // predicted result beats, oldest first
    logic [7:0]  comp_bytes[$];        // bytes of the component being built
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;
    bit          sender_calm    = 1'b0;
    int          stall_left     = 0;
    int          calm_left      = 0;

    // ------------------------------------------------------------------------
    // Local model of the normalizer: the mode register and the per-component
    // state that the block keeps between beats.
    // ------------------------------------------------------------------------
    logic [2:0] expected_mode;
    logic [1:0] esc_phase;
    logic [2:0] sticky_code;
    logic       first_byte;
    logic [2:0] oct_digits;
    logic [9:0] oct_value;
    logic [2:0] oct_count;

    function automatic bit letter_q(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit_q(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit hex_q(input logic [7:0] c);
        return digit_q(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic bit unreserved_q(input logic [7:0] c);
        return letter_q(c) || digit_q(c) || c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic bit subdelim_q(input logic [7:0] c);
        return c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
               c == "*" || c == "+" || c == "," || c == ";" || c == "=";
    endfunction

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // Only the first problem of a component is kept.
    function automatic void raise_status(input logic [2:0] code);
        if (sticky_code == ST_OK)
            sticky_code = code;
    endfunction

    function automatic void clear_component();
        esc_phase   = ESC_NONE;
        sticky_code = ST_OK;
        first_byte  = 1'b1;
        oct_digits  = 3'd0;
        oct_value   = 10'd0;
        oct_count   = 3'd0;
    endfunction

    function automatic void reset_prediction();
        expected_mode = MODE_SCHEME;
        clear_component();
    endfunction

    // Closes an IPv4 octet: empty, leading zero or above 255 is illegal.
    function automatic void finish_octet();
        if (oct_digits == 3'd0)
            raise_status(ST_ILLEGAL);
        else if (oct_digits == 3'd2 && oct_value < OCTET_MIN_2DIG)
            raise_status(ST_ILLEGAL);
        else if (oct_digits == 3'd3 && (oct_value < OCTET_MIN_3DIG || oct_value > OCTET_MAX))
            raise_status(ST_ILLEGAL);
        if (oct_count < OCTET_COUNT_SAT)
            oct_count = oct_count + 3'd1;
        oct_digits = 3'd0;
        oct_value  = 10'd0;
    endfunction

    // One of the two bytes after a percent sign; hex digits come out uppercase.
    function automatic logic [7:0] escape_digit(input logic [7:0] c);
        if (!hex_q(c))
            raise_status(ST_ILLEGAL);
        esc_phase = (esc_phase == ESC_FIRST) ? ESC_SECOND : ESC_NONE;
        return upper_of(c);
    endfunction

    function automatic logic [7:0] take_byte(input logic [7:0] c);
        logic [7:0] out;
        out = c;
        case (expected_mode) inside
            MODE_SCHEME:
            begin
                if (first_byte && !letter_q(c))
                    raise_status(ST_ILLEGAL);
                if (!(letter_q(c) || digit_q(c) || c == CH_PLUS || c == CH_MINUS ||
                      c == CH_DOT))
                    raise_status(ST_ILLEGAL);
                out = lower_of(c);
            end
            MODE_HOST:
            begin
                if (esc_phase != ESC_NONE)
                    out = escape_digit(c);
                else if (c == CH_PERCENT)
                    esc_phase = ESC_FIRST;
                else
                begin
                    if (!(subdelim_q(c) || unreserved_q(c)))
                        raise_status(ST_ILLEGAL);
                    out = lower_of(c);
                end
            end
            MODE_PORT:
            begin
                if (!digit_q(c))
                    raise_status(ST_ILLEGAL);
            end
            MODE_PATH:
            begin
                if (esc_phase != ESC_NONE)
                    out = escape_digit(c);
                else if (c == CH_PERCENT)
                    esc_phase = ESC_FIRST;
                else if (!(unreserved_q(c) || subdelim_q(c) || c == CH_COLON ||
                           c == CH_AT || c == CH_SLASH))
                    raise_status(ST_ILLEGAL);
            end
            MODE_IPV4:
            begin
                if (c == CH_DOT)
                begin
                    finish_octet();
                    // A fourth dot means a fifth octet is starting.
                    if (oct_count >= OCTET_LIMIT)
                        raise_status(ST_RANGE);
                end
                else if (digit_q(c))
                begin
                    if (oct_digits >= OCTET_DIG_MAX)
                    begin
                        raise_status(ST_RANGE);
                        oct_digits = OCTET_DIG_OVER;
                    end
                    else
                    begin
                        oct_value  = 10'(oct_value * 10'd10 + {2'd0, c - CH_ZERO});
                        oct_digits = oct_digits + 3'd1;
                    end
                end
                else
                    raise_status(ST_ILLEGAL);
            end
            default:
                raise_status(ST_ILLEGAL);
        endcase
        return out;
    endfunction

    // Checks made when a component that carried bytes comes to its end.
    function automatic void closing_checks();
        if (esc_phase != ESC_NONE)
            raise_status(ST_ILLEGAL);
        if (expected_mode == MODE_IPV4)
        begin
            finish_octet();
            if (oct_count < OCTET_LIMIT)
                raise_status(ST_ILLEGAL);
        end
        else if (expected_mode > MODE_IPV4)
            raise_status(ST_ILLEGAL);
    endfunction

    // Works out the result beat that one accepted input beat causes.
    function automatic result_t predict_normalized(input item_t it);
        result_t r;
        r.char_out = 8'h00;
        if (it.empty_component)
        begin
            r.end_of_component = 1'b1;
            if (first_byte)
            begin
                case (expected_mode) inside
                    MODE_SCHEME:           raise_status(ST_NO_SCHEME);
                    MODE_PATH, MODE_IPV4:  raise_status(ST_BAD_EMPTY);
                    MODE_HOST, MODE_PORT:  ;
                    default:               raise_status(ST_ILLEGAL);
                endcase
            end
            else
                closing_checks();
        end
        else
        begin
            r.char_out = take_byte(it.char_in);
            first_byte = 1'b0;
            r.end_of_component = it.last_char;
            if (it.last_char)
                closing_checks();
        end
        r.status = sticky_code;
        if (r.end_of_component)
            clear_component();
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and the result monitor. The monitor also drives the stall of
    // the result side: mostly short stalls, a few long ones, and now and then
    // a calm stretch with no stall at all.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t ns] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        int      roll;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat %h with nothing expected", result));
            else
            begin
                want = pending_results.pop_front();
                if (result.char_out !== want.char_out)
                    report_mismatch($sformatf("char_out %h, expected %h",
                                              result.char_out, want.char_out));
                if (result.end_of_component !== want.end_of_component)
                    report_mismatch($sformatf("end_of_component %b, expected %b",
                                              result.end_of_component,
                                              want.end_of_component));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, want.status));
            end
        end

        if (!rst_n)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            result_stall <= 1'b0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                result_stall <= 1'b0;
            else if (roll < 85)
            begin
                stall_left = $urandom_range(0, 2);
                result_stall <= 1'b1;
            end
            else if (roll < 95)
            begin
                stall_left = $urandom_range(7, 29);
                result_stall <= 1'b1;
            end
            else
            begin
                calm_left = $urandom_range(30, 150);
                result_stall <= 1'b0;
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uri_component_char_normalizer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side. Each call is made in the time step of a rising edge and
    // returns in the step of the edge at which the beat was accepted, with
    // valid still high so that a following beat can go out back to back.
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (sender_calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_beat(input item_t it);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(predict_normalized(it));
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] c, input bit last);
        item_t it;
        it.char_in         = c;
        it.last_char       = last;
        it.empty_component = 1'b0;
        send_beat(it);
    endtask

    // The byte and the last flag of an empty beat are don't-cares, so they
    // carry random values.
    task automatic send_empty();
        item_t it;
        it.char_in         = 8'($urandom_range(0, 255));
        it.last_char       = 1'($urandom_range(0, 1));
        it.empty_component = 1'b1;
        send_beat(it);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Drops valid, waits for every predicted beat, then lets the pipeline
    // settle.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // The mode register is only written with the block idle.
    task automatic write_mode(input logic [2:0] m);
        wait_idle();
        cfg_wdata <= m;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        expected_mode = m;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Empty scheme, a scheme opening with a digit, and a NUL byte after a
    // capital letter that must come back lowercase.
    task automatic test_scheme_rules();
        write_mode(MODE_SCHEME);
        send_empty();
        send_text("9");
        send_byte("A", 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // An empty host is fine. The escape has a lowercase hex digit to be
    // uppercased and a non-hex second digit; the byte after it is checked
    // and lowercased as usual.
    task automatic test_host_rules();
        write_mode(MODE_HOST);
        send_empty();
        send_text("%aGQ");
    endtask

    // Empty port is fine; a byte of 0xFF is not a digit.
    task automatic test_port_rules();
        write_mode(MODE_PORT);
        send_empty();
        send_byte("7", 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // An empty path is invalid. The second component ends with an empty beat
    // while its escape is still open.
    task automatic test_path_rules();
        write_mode(MODE_PATH);
        send_empty();
        send_byte(CH_PERCENT, 1'b0);
        send_byte("4", 1'b0);
        send_empty();
    endtask

    task automatic test_ipv4_rules();
        write_mode(MODE_IPV4);
        send_empty();
        send_text("0.0.0.0");
    endtask

    // The mode changes in the middle of a component and the component state
    // must carry over. The new mode is the top unused code, which passes
    // bytes through and flags every beat, empty ones included.
    task automatic test_mode_switch();
        write_mode(MODE_HOST);
        send_byte("a", 1'b0);
        write_mode(MODE_SPARE_HI);
        send_byte("b", 1'b1);
        send_empty();
    endtask

    // ------------------------------------------------------------------------
    // Random components. Most are well formed for their mode so that the
    // deeper checks (escapes, octet values, octet counts) get exercised, and
    // the rest are mutated, truncated or plain noise.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'($urandom_range(8'h61, 8'h7A));
        if ($urandom_range(0, 1) == 1)
            c = c - 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    function automatic void push_decimal(input int v);
        if (v >= 100)
            comp_bytes.push_back(8'(CH_ZERO + v / 100));
        if (v >= 10)
            comp_bytes.push_back(8'(CH_ZERO + (v / 10) % 10));
        comp_bytes.push_back(8'(CH_ZERO + v % 10));
    endfunction

    function automatic void build_dotted_quad();
        int n_oct;
        int roll;
        n_oct = ($urandom_range(0, 99) < 80) ? 4 : $urandom_range(1, 6);
        for (int i = 0; i < n_oct; i++)
        begin
            if (i > 0)
                comp_bytes.push_back(CH_DOT);
            roll = $urandom_range(0, 99);
            if (roll < 85)
            begin
                case ($urandom_range(0, 3))
                    0:       push_decimal($urandom_range(0, 9));
                    1:       push_decimal($urandom_range(10, 99));
                    2:       push_decimal($urandom_range(100, 255));
                    default: push_decimal($urandom_range(0, 1) * 255);
                endcase
            end
            else if (roll < 89)
                ;   // empty octet
            else if (roll < 93)
            begin
                comp_bytes.push_back(CH_ZERO);
                repeat ($urandom_range(1, 2)) comp_bytes.push_back(rand_digit());
            end
            else if (roll < 97)
                push_decimal($urandom_range(256, 999));
            else
                repeat ($urandom_range(4, 5)) comp_bytes.push_back(rand_digit());
        end
    endfunction

    function automatic void build_component(input logic [2:0] m);
        comp_bytes.delete();
        case (m) inside
            MODE_SCHEME:
            begin
                comp_bytes.push_back(rand_letter());
                repeat ($urandom_range(0, 7))
                begin
                    case ($urandom_range(0, 2))
                        0:       comp_bytes.push_back(rand_letter());
                        1:       comp_bytes.push_back(rand_digit());
                        default: comp_bytes.push_back(pick_from("+-."));
                    endcase
                end
            end
            MODE_HOST, MODE_PATH:
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 99) < 15)
                    begin
                        comp_bytes.push_back(CH_PERCENT);
                        comp_bytes.push_back(pick_from("0123456789abcdefABCDEF"));
                        comp_bytes.push_back(pick_from("0123456789abcdefABCDEF"));
                    end
                    else if ($urandom_range(0, 1) == 1)
                        comp_bytes.push_back(rand_letter());
                    else if (m == MODE_PATH)
                        comp_bytes.push_back(pick_from("0123456789-._~!$&'()*+,;=:@/"));
                    else
                        comp_bytes.push_back(pick_from("0123456789-._~!$&'()*+,;="));
                end
            end
            MODE_PORT:
                repeat ($urandom_range(1, 5)) comp_bytes.push_back(rand_digit());
            MODE_IPV4:
                build_dotted_quad();
            default:
                repeat ($urandom_range(1, 6))
                    comp_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    task automatic send_random_component();
        int kind;
        bit end_by_empty;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            send_empty();
            return;
        end
        build_component(expected_mode);
        if (kind < 20 && comp_bytes.size() > 0)
            comp_bytes[$urandom_range(0, comp_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        else if (kind < 26)
            foreach (comp_bytes[i])
                comp_bytes[i] = 8'($urandom_range(0, 255));
        else if (kind < 30 && comp_bytes.size() > 1)
            void'(comp_bytes.pop_back());
        end_by_empty = ($urandom_range(0, 99) < 15);
        foreach (comp_bytes[i])
            send_byte(comp_bytes[i], !end_by_empty && i == comp_bytes.size() - 1);
        if (end_by_empty)
            send_empty();
    endtask

    // Streams random components, switching mode every few components. The
    // unused codes get a small share of the run.
    task automatic test_random_components();
        int         stop_at;
        int         comp_left;
        logic [2:0] m;
        stop_at   = items_sent + RANDOM_ITEMS;
        comp_left = 0;
        while (items_sent < stop_at)
        begin
            if (comp_left == 0)
            begin
                if ($urandom_range(0, 99) < 85)
                    m = 3'($urandom_range(MODE_SCHEME, MODE_IPV4));
                else
                    m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                write_mode(m);
                comp_left = $urandom_range(2, 8);
            end
            // Some components go out with no gaps between beats.
            sender_calm = ($urandom_range(0, 4) == 0);
            send_random_component();
            comp_left--;
        end
        sender_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        reset_prediction();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scheme_rules();
        test_host_rules();
        test_port_rules();
        test_path_rules();
        test_ipv4_rules();
        test_mode_switch();
        test_random_components();

        wait_idle();
        if (mismatch_count == 0)
            $display("uri_component_char_normalizer regression: pass");
        else
            $display("uri_component_char_normalizer regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/uricn_pkg.sv
rtl/core/uricn_step.sv
rtl/core/uri_component_char_normalizer.sv
tb/tb_uri_component_char_normalizer.sv
